FILE: hdl/otsu_pkg.sv
// Shared constants, payload types and widths for the Otsu threshold block.
package otsu_pkg;

    localparam int COUNT_BITS = 20;
    localparam int CW    = COUNT_BITS + 1;       // bin, pixel and class counts
    localparam int SW    = CW + 8;               // gray-level sums
    localparam int DW    = CW + SW;              // N*s1, S*w1 and their difference
    localparam int NUMW  = 2 * DW;               // squared difference
    localparam int DENW  = 2 * CW;               // w1*w2
    localparam int PW    = NUMW + DW;            // multiplier product
    localparam int DIG   = 8;                    // multiplier digit per cycle
    localparam int NSTEP = (DW + DIG - 1) / DIG;
    localparam int STW   = $clog2(NSTEP);

    typedef struct packed {
        logic [7:0] pixel;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [7:0] threshold;
        logic       overflow;
    } t_out;

endpackage

FILE: hdl/otsu_mul.sv
// Digit-serial multiplier: one 8-bit digit of the B operand per cycle.
module otsu_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [otsu_pkg::NUMW-1:0]  i_a,
    input  logic [otsu_pkg::DW-1:0]    i_b,
    output logic                       o_done,
    output logic [otsu_pkg::PW-1:0]    o_prod
);

    logic [otsu_pkg::PW-1:0]  r_a;
    logic [otsu_pkg::DW-1:0]  r_b;
    logic [otsu_pkg::PW-1:0]  r_acc;
    logic [otsu_pkg::STW-1:0] r_cnt;
    logic                     r_busy;
    logic                     r_done;
    logic [otsu_pkg::PW-1:0]  n_part;
    logic                     last_step;

    assign n_part    = r_a * otsu_pkg::PW'(r_b[otsu_pkg::DIG-1:0]);
    assign last_step = (r_cnt == otsu_pkg::STW'(otsu_pkg::NSTEP - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last_step;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last_step) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= otsu_pkg::PW'(i_a);
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + n_part;
            r_a   <= r_a << otsu_pkg::DIG;
            r_b   <= r_b >> otsu_pkg::DIG;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

FILE: hdl/otsu_threshold.sv
// Top level: pixel histogram in block RAM, Otsu sweep sequencer and output register.
// Pixels are taken one per clock while the sequencer is idle into a 256-bin histogram
// held in a RAM with registered read; a read-modify-write pipeline with one forwarding
// register keeps back-to-back pixels of the same gray level exact. A pixel marked last
// stops input, and after a drain state the sequencer sweeps bins 0..255: where a class
// is empty the bin only passes through the read, accumulate and check states, and
// otherwise six products run one after the other on the shared 8-bit digit-serial
// multiplier. The result waits in an output register; the histogram is then cleared
// at once through per-bin valid bits and the next image may stream in.
module otsu_threshold (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  otsu_pkg::t_in    i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output otsu_pkg::t_out   o_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DRAIN = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_ACC   = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;
    localparam logic [2:0] S_MST   = 3'd5;
    localparam logic [2:0] S_MWT   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    localparam logic [2:0] OP_A   = 3'd0;
    localparam logic [2:0] OP_B   = 3'd1;
    localparam logic [2:0] OP_NUM = 3'd2;
    localparam logic [2:0] OP_DEN = 3'd3;
    localparam logic [2:0] OP_LHS = 3'd4;
    localparam logic [2:0] OP_RHS = 3'd5;

    localparam int CW   = otsu_pkg::CW;
    localparam int SW   = otsu_pkg::SW;
    localparam int DW   = otsu_pkg::DW;
    localparam int NUMW = otsu_pkg::NUMW;
    localparam int DENW = otsu_pkg::DENW;
    localparam int PW   = otsu_pkg::PW;

    // histogram RAM and per-bin valid bits
    logic [CW-1:0] r_mem [256];
    logic [255:0]  r_vld;
    logic [CW-1:0] r_rdata;
    logic          r_rvld;
    logic [7:0]    raddr;

    logic [2:0]    r_state;
    logic [2:0]    r_op;
    logic [CW-1:0] r_n;
    logic [SW-1:0] r_s;
    logic          r_ovf;

    // pixel pipeline
    logic          r_p1;
    logic [7:0]    r_p1_addr;
    logic          r_wen_d;
    logic [7:0]    r_waddr;
    logic [CW-1:0] r_wdata;
    logic [CW-1:0] n_h;
    logic          accept;
    logic          counted;

    // sweep
    logic [7:0]      r_t;
    logic [CW-1:0]   r_w1;
    logic [SW-1:0]   r_s1;
    logic [DW-1:0]   r_a;
    logic [DW-1:0]   r_d;
    logic [NUMW-1:0] r_num;
    logic [DENW-1:0] r_den;
    logic [PW-1:0]   r_lhs;
    logic [NUMW-1:0] r_best_num;
    logic [DENW-1:0] r_best_den;
    logic [7:0]      r_best;
    logic [CW-1:0]   hval;
    logic [CW-1:0]   n_w1;
    logic            skip;

    logic            mstart;
    logic [NUMW-1:0] ma;
    logic [DW-1:0]   mb;
    logic            mdone;
    logic [PW-1:0]   mprod;

    logic            r_ovld;
    otsu_pkg::t_out  r_odata;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign counted = !r_n[CW-1];
    assign raddr   = (r_state == S_IDLE) ? i_data.pixel : r_t;
    assign hval    = r_rvld ? r_rdata : '0;
    assign n_w1    = r_w1 + hval;
    assign skip    = (r_w1 == '0) || (r_w1 >= r_n);
    assign mstart  = (r_state == S_MST);

    // the transfer just before may hit the same bin, whose new count the read missed
    assign n_h = ((r_wen_d && r_waddr == r_p1_addr) ? r_wdata : hval) + 1'b1;

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[raddr];
        if (r_p1) begin
            r_mem[r_p1_addr] <= n_h;
        end
        r_waddr <= r_p1_addr;
        r_wdata <= n_h;
    end

    always_comb begin
        ma = '0;
        mb = '0;
        case (r_op)
            OP_A: begin
                ma = NUMW'(r_n);
                mb = DW'(r_s1);
            end
            OP_B: begin
                ma = NUMW'(r_s);
                mb = DW'(r_w1);
            end
            OP_NUM: begin
                ma = NUMW'(r_d);
                mb = r_d;
            end
            OP_DEN: begin
                ma = NUMW'(r_w1);
                mb = DW'(r_n - r_w1);
            end
            OP_LHS: begin
                ma = r_num;
                mb = DW'(r_best_den);
            end
            OP_RHS: begin
                ma = r_best_num;
                mb = DW'(r_den);
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    otsu_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mstart),
        .i_a     (ma),
        .i_b     (mb),
        .o_done  (mdone),
        .o_prod  (mprod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= '0;
            r_rvld  <= 1'b0;
            r_p1    <= 1'b0;
            r_wen_d <= 1'b0;
            r_n     <= '0;
            r_s     <= '0;
            r_ovf   <= 1'b0;
            r_ovld  <= 1'b0;
            r_op    <= OP_A;
            r_t     <= '0;
        end else begin
            r_rvld  <= r_vld[raddr];
            r_p1    <= accept && counted;
            r_wen_d <= r_p1;
            if (r_p1) begin
                r_vld[r_p1_addr] <= 1'b1;
            end
            if (o_valid && i_ready) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (counted) begin
                            r_n <= r_n + 1'b1;
                            r_s <= r_s + SW'(i_data.pixel);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_data.last) begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    r_t     <= '0;
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (skip) begin
                        if (r_t == 8'd255) begin
                            r_state <= S_OUT;
                        end else begin
                            r_t     <= r_t + 1'b1;
                            r_state <= S_RD;
                        end
                    end else begin
                        r_op    <= OP_A;
                        r_state <= S_MST;
                    end
                end
                S_MST: begin
                    r_state <= S_MWT;
                end
                S_MWT: begin
                    if (mdone) begin
                        if (r_op == OP_RHS) begin
                            if (r_t == 8'd255) begin
                                r_state <= S_OUT;
                            end else begin
                                r_t     <= r_t + 1'b1;
                                r_state <= S_RD;
                            end
                        end else begin
                            r_op    <= r_op + 1'b1;
                            r_state <= S_MST;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ovld) begin
                        r_ovld  <= 1'b1;
                        r_vld   <= '0;
                        r_n     <= '0;
                        r_s     <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // sweep datapath, pixel address register and output register
    always_ff @(posedge i_clk) begin
        r_p1_addr <= i_data.pixel;
        if (r_state == S_DRAIN) begin
            r_w1       <= '0;
            r_s1       <= '0;
            r_best_num <= '0;
            r_best_den <= DENW'(1);
            r_best     <= '0;
        end
        if (r_state == S_ACC) begin
            r_w1 <= n_w1;
            r_s1 <= r_s1 + SW'(r_t) * SW'(hval);
        end
        if (r_state == S_MWT && mdone) begin
            case (r_op)
                OP_A:   r_a <= mprod[DW-1:0];
                OP_B:   r_d <= (r_a >= mprod[DW-1:0]) ? r_a - mprod[DW-1:0]
                                                      : mprod[DW-1:0] - r_a;
                OP_NUM: r_num <= mprod[NUMW-1:0];
                OP_DEN: r_den <= mprod[DENW-1:0];
                OP_LHS: r_lhs <= mprod;
                OP_RHS: begin
                    if (r_lhs > mprod) begin
                        r_best_num <= r_num;
                        r_best_den <= r_den;
                        r_best     <= r_t;
                    end
                end
                default: r_a <= r_a;
            endcase
        end
        if (r_state == S_OUT && !r_ovld) begin
            r_odata.threshold <= r_best;
            r_odata.overflow  <= r_ovf;
        end
    end

    assign o_valid = r_ovld;
    assign o_data  = r_odata;

    a_stop_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_data.last) |=> !o_ready)
        else $error("input still open after last pixel");

    a_class_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MST) |-> (r_w1 != '0 && r_w1 < r_n))
        else $error("variance product started with an empty class");

    a_result_from_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_OUT))
        else $error("result appeared outside sweep end");

    a_mul_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mstart |=> !mdone)
        else $error("multiplier done right after start");

endmodule
